### hdl/pscull_pkg.sv
// ----------------------------------------------------------------------------
// pscull_pkg
// Shared types and constants for the polyline segment cull and transform core.
// ----------------------------------------------------------------------------
package pscull_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COEFF_WIDTH_DEF = 20;
  localparam int ROW_WIDTH = 60;
  localparam int CFG_DATA_WIDTH = 60;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int TOL_WIDTH = 10;
  localparam int SCREEN_WIDTH = 16;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;
  localparam int MID_CNT_WIDTH = $clog2(MID_DEPTH + 1);
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 10'd16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_PYRAMID_MODE   = 3'd0,
    REG_MATRIX_ROW_X   = 3'd1,
    REG_MATRIX_ROW_Y   = 3'd2,
    REG_MATRIX_ROW_Z   = 3'd3,
    REG_CENTER_X       = 3'd4,
    REG_CENTER_Y       = 3'd5,
    REG_FACE_TOLERANCE = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                    pyramid_mode;
    logic [ROW_WIDTH-1:0]    matrix_row_x;
    logic [ROW_WIDTH-1:0]    matrix_row_y;
    logic [ROW_WIDTH-1:0]    matrix_row_z;
    logic signed [15:0]      center_x;
    logic signed [15:0]      center_y;
    logic [TOL_WIDTH-1:0]    face_tolerance;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          starts_line;
  } vertex_t;

  typedef struct packed {
    logic signed [SCREEN_WIDTH-1:0] start_x;
    logic signed [SCREEN_WIDTH-1:0] start_y;
    logic signed [SCREEN_WIDTH-1:0] end_x;
    logic signed [SCREEN_WIDTH-1:0] end_y;
  } segment_t;

endpackage

### hdl/pscull_fifo.sv
// ----------------------------------------------------------------------------
// pscull_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module pscull_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             data_in,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             data_out,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/pscull_front.sv
// ----------------------------------------------------------------------------
// pscull_front
// Vertex transform and segment classification: two-stage multiply/sum
// pipeline, face tagging and visibility decision.
// ----------------------------------------------------------------------------
module pscull_front import pscull_pkg::*; #(
  parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          push,
  input  vertex_t                       vertex,
  output logic                          full,
  input  logic [MID_CNT_WIDTH-1:0]      mid_count,
  output logic                          mid_push,
  output logic [2*(COEFF_WIDTH+4):0]    mid_item
);

  localparam int ROT_W  = COEFF_WIDTH + 4;
  localparam int PROD_W = COEFF_WIDTH + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int TAG_W  = COORD_WIDTH + 3;
  localparam int FV_W   = COEFF_WIDTH + 2;
  localparam int ROWV_W = (3 * COEFF_WIDTH > ROW_WIDTH) ? 3 * COEFF_WIDTH : ROW_WIDTH;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (COORD_WIDTH - 3);
  localparam logic signed [TAG_W-1:0] ONE = TAG_W'(1) <<< (COORD_WIDTH - 2);

  logic [ROWV_W-1:0]               rowv [3];
  logic signed [COEFF_WIDTH-1:0]   coef [3][3];
  logic signed [COORD_WIDTH-1:0]   pt [3];
  logic signed [COORD_WIDTH-1:0]   last_pt [3];
  logic [4:0]                      tags;
  logic [4:0]                      last_tags;
  logic                            accept;
  logic                            have_prev;

  logic                            s1_valid;
  logic                            s1_first;
  logic signed [PROD_W-1:0]        s1_prod [3][3];
  logic [4:0]                      s1_tags;
  logic [4:0]                      s1_ptags;

  logic signed [SUM_W-1:0]         sum [3];
  logic                            s2_valid;
  logic                            s2_first;
  logic signed [ROT_W-1:0]         s2_rot [3];
  logic [4:0]                      s2_tags;
  logic [4:0]                      s2_ptags;
  logic signed [ROT_W-1:0]         prev_rot_y;

  logic signed [FV_W-1:0]          cy0;
  logic signed [FV_W-1:0]          cy1;
  logic signed [FV_W-1:0]          cy2;
  logic signed [FV_W-1:0]          fdot [5];
  logic [4:0]                      face_vis;
  logic [4:0]                      shared;
  logic                            draw;

  function automatic logic on_face(input logic signed [TAG_W-1:0] d,
                                   input logic [TOL_WIDTH-1:0] tol);
    logic [TAG_W-1:0] mag;
    mag = d[TAG_W-1] ? TAG_W'(-d) : TAG_W'(d);
    return mag < TAG_W'(tol);
  endfunction

  function automatic logic [4:0] face_tags(input logic signed [COORD_WIDTH-1:0] px,
                                           input logic signed [COORD_WIDTH-1:0] py,
                                           input logic signed [COORD_WIDTH-1:0] pz,
                                           input logic [TOL_WIDTH-1:0] tol);
    logic signed [TAG_W-1:0] ex;
    logic signed [TAG_W-1:0] ey;
    logic signed [TAG_W-1:0] ez;
    logic [4:0]              t;
    ex = TAG_W'(px) <<< 1;
    ey = TAG_W'(py) <<< 1;
    ez = TAG_W'(pz);
    t[0] = on_face(ez - ONE, tol);
    t[1] = on_face(ex - ez - ONE, tol);
    t[2] = on_face(-ex - ez - ONE, tol);
    t[3] = on_face(ey - ez - ONE, tol);
    t[4] = on_face(-ey - ez - ONE, tol);
    return t;
  endfunction

  function automatic logic not_pos(input logic signed [FV_W-1:0] v);
    return v[FV_W-1] || (v == '0);
  endfunction

  assign full   = (MID_CNT_WIDTH'(s1_valid) + MID_CNT_WIDTH'(s2_valid) + mid_count)
                  >= MID_CNT_WIDTH'(MID_DEPTH);
  assign accept = push && !full;

  always_comb begin
    rowv[0] = ROWV_W'(cfg.matrix_row_x);
    rowv[1] = ROWV_W'(cfg.matrix_row_y);
    rowv[2] = ROWV_W'(cfg.matrix_row_z);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = $signed(rowv[r][c*COEFF_WIDTH +: COEFF_WIDTH]);
      end
    end
    pt[0] = vertex.point_x;
    pt[1] = vertex.point_y;
    pt[2] = vertex.point_z;
  end

  // face plane distances, previous vertex tagged with the current tolerance
  assign tags      = face_tags(vertex.point_x, vertex.point_y, vertex.point_z,
                               cfg.face_tolerance);
  assign last_tags = face_tags(last_pt[0], last_pt[1], last_pt[2], cfg.face_tolerance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first   <= vertex.starts_line || !have_prev;
      s1_tags    <= tags;
      s1_ptags   <= last_tags;
      last_pt[0] <= vertex.point_x;
      last_pt[1] <= vertex.point_y;
      last_pt[2] <= vertex.point_z;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod[r][c] <= coef[r][c] * pt[c];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'(s1_prod[r][0]) + SUM_W'(s1_prod[r][1])
             + SUM_W'(s1_prod[r][2]) + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_first <= s1_first;
      s2_tags  <= s1_tags;
      s2_ptags <= s1_ptags;
      for (int r = 0; r < 3; r++) begin
        s2_rot[r] <= sum[r][COORD_WIDTH-2 +: ROT_W];
      end
    end
    if (s2_valid) begin
      prev_rot_y <= s2_rot[1];
    end
  end

  // depth row against the face normals
  always_comb begin
    cy0 = FV_W'(coef[1][0]) <<< 1;
    cy1 = FV_W'(coef[1][1]) <<< 1;
    cy2 = FV_W'(coef[1][2]);
    fdot[0] = cy2;
    fdot[1] = cy0 - cy2;
    fdot[2] = -cy0 - cy2;
    fdot[3] = cy1 - cy2;
    fdot[4] = -cy1 - cy2;
    for (int f = 0; f < 5; f++) begin
      face_vis[f] = not_pos(fdot[f]);
    end
  end

  always_comb begin
    shared = s2_ptags & s2_tags;
    if (s2_first) begin
      draw = 1'b0;
    end else if (!cfg.pyramid_mode) begin
      draw = (s2_rot[1][ROT_W-1] || (s2_rot[1] == '0))
          && (prev_rot_y[ROT_W-1] || (prev_rot_y == '0));
    end else if (shared != '0) begin
      draw = |(shared & face_vis);
    end else begin
      draw = (|(s2_ptags & face_vis)) && (|(s2_tags & face_vis));
    end
  end

  assign mid_push = s2_valid;
  assign mid_item = {draw, s2_rot[0], s2_rot[2]};

endmodule

### hdl/pscull_back.sv
// ----------------------------------------------------------------------------
// pscull_back
// Screen mapping: center offset, rounding, saturation and segment assembly
// from the previous and current endpoints.
// ----------------------------------------------------------------------------
module pscull_back import pscull_pkg::*; #(
  parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  logic                          clk,
  input  cfg_t                          cfg,
  input  logic                          mid_empty,
  input  logic [2*(COEFF_WIDTH+4):0]    mid_item,
  output logic                          mid_pop,
  input  logic                          out_full,
  output logic                          out_push,
  output segment_t                      out_item
);

  localparam int ROT_W = COEFF_WIDTH + 4;
  localparam int SCR_W = ((ROT_W > 24) ? ROT_W : 24) + 2;
  localparam int SH_W  = SCR_W - 8;

  logic                           draw;
  logic signed [ROT_W-1:0]        rot_x;
  logic signed [ROT_W-1:0]        rot_z;
  logic signed [SCREEN_WIDTH-1:0] cur_x;
  logic signed [SCREEN_WIDTH-1:0] cur_y;
  logic signed [ROT_W-1:0]        prev_rot_x;
  logic signed [ROT_W-1:0]        prev_rot_z;

  function automatic logic signed [SCREEN_WIDTH-1:0] to_screen(
      input logic signed [ROT_W-1:0] rot, input logic signed [15:0] center);
    logic signed [SCR_W-1:0] v;
    logic signed [SH_W-1:0]  sh;
    logic [SH_W-16:0]        hi;
    v  = SCR_W'(rot) + SCR_W'($signed({center, 8'h80}));
    sh = v[SCR_W-1:8];
    hi = sh[SH_W-1:15];
    if ((hi == '0) || (hi == '1)) begin
      return sh[15:0];
    end
    return sh[SH_W-1] ? 16'sh8000 : 16'sh7fff;
  endfunction

  assign {draw, rot_x, rot_z} = mid_item;
  assign cur_x    = to_screen(rot_x, cfg.center_x);
  assign cur_y    = to_screen(rot_z, cfg.center_y);
  assign mid_pop  = !mid_empty && !out_full;
  assign out_push = mid_pop && draw;

  // start point mapped with the current offsets
  always_comb begin
    out_item.start_x = to_screen(prev_rot_x, cfg.center_x);
    out_item.start_y = to_screen(prev_rot_z, cfg.center_y);
    out_item.end_x   = cur_x;
    out_item.end_y   = cur_y;
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      prev_rot_x <= rot_x;
      prev_rot_z <= rot_z;
    end
  end

endmodule

### hdl/polyline_segment_cull_transform_core.sv
// ----------------------------------------------------------------------------
// polyline_segment_cull_transform_core
// Rotates polyline vertices, culls segments and emits screen endpoints.
//
//   channel   handshake        payload     direction
//   vertex    push / full      vertex_t    in
//   segment   pop / empty      segment_t   out
//   config    cfg_write        cfg_data    in
//
// One vertex per cycle sustained while full is low; a segment request passes
// the two transform stages and the midpoint and result queues (screen mapping
// between the queues is combinational). The midpoint queue and the transform
// stages hold four vertices in all; full rises when that budget is used.
// A stalled output fills the result queue, then the midpoint queue, then full.
// Synchronous reset clears queues, pipeline valids and config (tolerance to TOL_RESET).
// ----------------------------------------------------------------------------
module polyline_segment_cull_transform_core import pscull_pkg::*; #(
  parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  vertex_t                    vertex,
  output logic                       empty,
  input  logic                       pop,
  output segment_t                   segment,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int MID_W = 2 * (COEFF_WIDTH + 4) + 1;

  cfg_t                     cfg;
  logic                     mid_push;
  logic [MID_W-1:0]         mid_item_in;
  logic [MID_W-1:0]         mid_item_out;
  logic                     mid_full;
  logic                     mid_empty;
  logic                     mid_pop;
  logic [MID_CNT_WIDTH-1:0] mid_count;
  logic                     out_push;
  logic                     out_full;
  segment_t                 out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pyramid_mode   <= 1'b0;
      cfg.matrix_row_x   <= '0;
      cfg.matrix_row_y   <= '0;
      cfg.matrix_row_z   <= '0;
      cfg.center_x       <= '0;
      cfg.center_y       <= '0;
      cfg.face_tolerance <= TOL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PYRAMID_MODE:   cfg.pyramid_mode   <= cfg_data[0];
        REG_MATRIX_ROW_X:   cfg.matrix_row_x   <= cfg_data[ROW_WIDTH-1:0];
        REG_MATRIX_ROW_Y:   cfg.matrix_row_y   <= cfg_data[ROW_WIDTH-1:0];
        REG_MATRIX_ROW_Z:   cfg.matrix_row_z   <= cfg_data[ROW_WIDTH-1:0];
        REG_CENTER_X:       cfg.center_x       <= $signed(cfg_data[15:0]);
        REG_CENTER_Y:       cfg.center_y       <= $signed(cfg_data[15:0]);
        REG_FACE_TOLERANCE: cfg.face_tolerance <= cfg_data[TOL_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  pscull_front #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .vertex    (vertex),
    .full      (full),
    .mid_count (mid_count),
    .mid_push  (mid_push),
    .mid_item  (mid_item_in)
  );

  pscull_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (mid_push),
    .data_in  (mid_item_in),
    .full     (mid_full),
    .pop      (mid_pop),
    .data_out (mid_item_out),
    .empty    (mid_empty),
    .count    (mid_count)
  );

  pscull_back #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_back (
    .clk       (clk),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_item  (mid_item_out),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  pscull_fifo #(
    .WIDTH ($bits(segment_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .data_in  (out_item),
    .full     (out_full),
    .pop      (pop),
    .data_out (segment),
    .empty    (empty),
    .count    ()
  );

  // midpoint queue never overflows: the front reserves a slot per vertex
  logic unused_mid_full;
  assign unused_mid_full = mid_full;

endmodule
